// ===== rtl/bmrp_pkg.sv =====
// Shared constants, types and the command code lookup for the battery monitor reply parser.
`default_nettype none

package bmrp_pkg;

  localparam logic [7:0] HEAD_BYTE  = 8'h3A;
  localparam logic [7:0] ADDR_BYTE  = 8'h16;
  localparam logic [7:0] END_BYTE_1 = 8'h0D;
  localparam logic [7:0] END_BYTE_2 = 8'h0A;

  // Temperature offset in tenths of a degree, added as its two's complement.
  localparam logic [16:0] TEMP_OFFSET_NEG = 17'(18'h20000 - 18'd2731);

  localparam int NUM_SLOTS  = 14;
  localparam int RESULT_CAP = 7;

  // Slot numbers of the commands that need their own decoding.
  localparam logic [3:0] SLOT_TEMP      = 4'd0;
  localparam logic [3:0] SLOT_CURRENT   = 4'd2;
  localparam logic [3:0] SLOT_CELLS_LO  = 4'd8;
  localparam logic [3:0] SLOT_CELLS_MID = 4'd9;
  localparam logic [3:0] SLOT_CELLS_HI  = 4'd10;
  localparam logic [3:0] SLOT_MOS       = 4'd11;
  localparam logic [3:0] SLOT_SWITCH    = 4'd12;
  localparam logic [3:0] SLOT_RAW_BYTE  = 4'd13;

  localparam logic [7:0] SLOT_CODES [NUM_SLOTS] = '{
    8'h08, 8'h09, 8'h0A, 8'h0D, 8'h0E, 8'h0F, 8'h10,
    8'h17, 8'h24, 8'h25, 8'h26, 8'h37, 8'h38, 8'h55
  };

  typedef struct packed {
    logic       hit;
    logic [3:0] slot;
  } slot_hit_t;

  // Maps a command byte to its slot; hit is low for an unknown code.
  function automatic slot_hit_t slot_lookup(input logic [7:0] code);
    slot_hit_t res;
    res.hit  = 1'b0;
    res.slot = '0;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      if (SLOT_CODES[k] == code) begin
        res.hit  = 1'b1;
        res.slot = 4'(k);
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/battery_monitor_reply_parser_unit.sv =====
// Top level of the battery monitor reply parser: frame parsing, payload buffer and result decode.
//
//  Channel  | Direction | Signals                               | Content
//  ---------+-----------+---------------------------------------+------------------------------
//  s_axis   | in        | tvalid, tready, tdata[7:0]            | rx_byte, one reply byte
//  m_axis   | out       | tvalid, tready, tdata[39:0], tuser,   | decoded result of a frame
//           |           | tlast                                 |
//  cfg      | in        | cfg_wen, cfg_wdata                    | mos_cut_off register
//
// Each received byte is taken while the parser walks the frame.
// When the trailer closes a good frame, the block stops taking bytes and
// emits one to seven results; each result goes through two reads of the
// payload buffer, one pass through the shared adder and an output state
// that waits while the consumer holds m_axis_tready low.
// Reset (rst, synchronous, active high) returns the parser to header hunting
// and clears the seen mask and the mos_cut_off register. The payload buffer
// is not cleared: only bytes of the current frame are ever read back.
`default_nettype none

module battery_monitor_reply_parser_unit
  import bmrp_pkg::*;
#(
  parameter int MAX_PAYLOAD = 14,
  parameter int CELL_COUNT  = 21
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // Result stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [3:0] slot, [8:4] cell_res, [25:9] value, [39:26] seen_mask
  output logic [39:0]      m_axis_tdata,
  output logic             m_axis_tuser,   // [0] value_valid
  output logic             m_axis_tlast,   // last result of the frame
  // Configuration register write.
  input  wire logic        cfg_wen,
  input  wire logic        cfg_wdata       // mos_cut_off
);

  // The buffer holds the payload plus the two checksum bytes.
  localparam int BUF_LEN = MAX_PAYLOAD + 2;
  localparam int AW      = $clog2(BUF_LEN);
  localparam int CW      = $clog2(MAX_PAYLOAD + 3);

  typedef enum logic [3:0] {
    ST_HUNT,
    ST_HEAD,
    ST_CMD,
    ST_LEN,
    ST_BODY,
    ST_END1,
    ST_END2,
    ST_RD_LO,
    ST_RD_HI,
    ST_CALC,
    ST_OUT
  } state_t;

  state_t         state;
  logic           mos_cut_off;
  logic [3:0]     slot_held;
  logic [7:0]     payload_length;
  logic [CW-1:0]  byte_count;
  logic [13:0]    seen_bits;
  logic [2:0]     idx;
  logic [7:0]     lo_byte;

  logic [3:0]     out_slot;
  logic [4:0]     out_cell;
  logic [16:0]    out_value;
  logic           out_value_valid;
  logic           out_last;
  logic           out_tvalid;

  // Payload buffer, one write and one registered read per cycle.
  logic [7:0]     frame_mem [BUF_LEN];
  logic [7:0]     rd_data;
  logic [AW-1:0]  rd_addr;

  logic           in_fire;
  logic [7:0]     rx_byte;
  slot_hit_t      cmd;
  state_t         restart_state;
  logic           end_of_body;

  logic           is_list;
  logic [4:0]     list_base;
  logic [7:0]     list_words;
  logic [3:0]     idx_plus;
  logic           cur_ok;
  logic           next_ok;

  logic [15:0]    word;
  logic [16:0]    operand_a;
  logic [16:0]    addend;
  logic [16:0]    sum;

  assign rx_byte = s_axis_tdata;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // Bytes are taken only while the frame is being parsed.
  assign s_axis_tready = (state != ST_RD_LO) && (state != ST_RD_HI) &&
                         (state != ST_CALC) && (state != ST_OUT);

  assign cmd           = slot_lookup(rx_byte);
  assign restart_state = (rx_byte == HEAD_BYTE) ? ST_HEAD : ST_HUNT;
  assign end_of_body   = ({1'b0, 8'(byte_count) + 8'd1} >= ({1'b0, payload_length} + 9'd2));

  // Cell list commands: slots 8, 9 and 10 start at cells 0, 7 and 14.
  assign is_list    = (slot_held == SLOT_CELLS_LO) || (slot_held == SLOT_CELLS_MID) ||
                      (slot_held == SLOT_CELLS_HI);
  assign list_base  = 5'({slot_held[1:0], 3'b000}) - 5'(slot_held[1:0]);
  assign list_words = 8'(({1'b0, payload_length} + 9'd1) >> 1);
  assign idx_plus   = 4'(idx) + 4'd1;

  // A list word is emitted while it exists, the result cap is not reached and
  // its cell number is below the cell count.
  assign cur_ok  = (8'(idx) < list_words) && (4'(idx) < 4'(RESULT_CAP)) &&
                   ((7'(list_base) + 7'(idx)) < 7'(CELL_COUNT));
  assign next_ok = (8'(idx_plus) < list_words) && (idx_plus < 4'(RESULT_CAP)) &&
                   ((7'(list_base) + 7'(idx_plus)) < 7'(CELL_COUNT));

  // Low byte address in ST_RD_LO, high byte in ST_RD_HI.
  assign rd_addr = AW'({idx, (state == ST_RD_HI)});

  always_ff @(posedge clk) begin
    if (state == ST_BODY && in_fire) begin
      frame_mem[byte_count[AW-1:0]] <= rx_byte;
    end
    rd_data <= frame_mem[rd_addr];
  end

  // Shared adder: every decoded value is one operand plus an offset.
  assign word = {rd_data, lo_byte};
  assign sum  = operand_a + addend;

  always_comb begin
    operand_a = {1'b0, word};
    addend    = '0;
    unique case (slot_held) inside
      SLOT_TEMP: begin
        addend = TEMP_OFFSET_NEG;
      end
      SLOT_CURRENT: begin
        operand_a = {word[15], word};
      end
      SLOT_CELLS_LO, SLOT_CELLS_MID, SLOT_CELLS_HI: begin
        operand_a = cur_ok ? {1'b0, word} : '0;
      end
      SLOT_MOS: begin
        operand_a = 17'(mos_cut_off);
      end
      SLOT_SWITCH: begin
        operand_a = 17'd1;
      end
      SLOT_RAW_BYTE: begin
        operand_a = 17'(lo_byte);
      end
      default: begin
        operand_a = {1'b0, word};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_HUNT;
      mos_cut_off    <= 1'b0;
      slot_held      <= '0;
      payload_length <= '0;
      byte_count     <= '0;
      seen_bits      <= '0;
      idx            <= '0;
      out_tvalid     <= 1'b0;
    end else begin
      if (cfg_wen) begin
        mos_cut_off <= cfg_wdata;
      end
      unique case (state)
        ST_HUNT: begin
          if (in_fire) begin
            state <= restart_state;
          end
        end
        ST_HEAD: begin
          if (in_fire) begin
            state <= (rx_byte == ADDR_BYTE) ? ST_CMD : restart_state;
          end
        end
        ST_CMD: begin
          if (in_fire) begin
            if (cmd.hit) begin
              slot_held <= cmd.slot;
              state     <= ST_LEN;
            end else begin
              state <= restart_state;
            end
          end
        end
        ST_LEN: begin
          if (in_fire) begin
            if (9'(rx_byte) > 9'(MAX_PAYLOAD)) begin
              state <= restart_state;
            end else begin
              payload_length <= rx_byte;
              byte_count     <= '0;
              state          <= ST_BODY;
            end
          end
        end
        ST_BODY: begin
          if (in_fire) begin
            byte_count <= byte_count + 1'b1;
            if (end_of_body) begin
              state <= ST_END1;
            end
          end
        end
        ST_END1: begin
          if (in_fire) begin
            state <= (rx_byte == END_BYTE_1) ? ST_END2 : restart_state;
          end
        end
        ST_END2: begin
          if (in_fire) begin
            if (rx_byte == END_BYTE_2) begin
              seen_bits <= seen_bits | (14'd1 << slot_held);
              idx       <= '0;
              state     <= ST_RD_LO;
            end else begin
              state <= restart_state;
            end
          end
        end
        ST_RD_LO: begin
          state <= ST_RD_HI;
        end
        ST_RD_HI: begin
          lo_byte <= rd_data;
          state   <= ST_CALC;
        end
        ST_CALC: begin
          out_slot        <= slot_held;
          out_value       <= sum;
          out_cell        <= (is_list && cur_ok) ? 5'(list_base + 5'(idx)) : 5'd0;
          out_value_valid <= !is_list || cur_ok;
          out_last        <= !is_list || !next_ok;
          out_tvalid      <= 1'b1;
          state           <= ST_OUT;
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            out_tvalid <= 1'b0;
            if (out_last) begin
              state <= ST_HUNT;
            end else begin
              idx   <= idx + 1'b1;
              state <= ST_RD_LO;
            end
          end
        end
        default: begin
          state <= ST_HUNT;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_tvalid;
  assign m_axis_tdata  = {seen_bits, out_value, out_cell, out_slot};
  assign m_axis_tuser  = out_value_valid;
  assign m_axis_tlast  = out_last;

  // The parser never takes a byte while a result is on offer.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input accepted while a result is pending");

  // A result always reports its own slot as seen.
  a_slot_seen: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> seen_bits[out_slot])
    else $error("result slot missing from seen mask");

  // An empty list result is the only and last result of its frame.
  a_empty_list: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tlast && out_value == '0 && out_cell == '0))
    else $error("empty list result malformed");

  // A result held by the consumer leaves the sequencer parked.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (state == ST_OUT && $stable(idx)))
    else $error("sequencer moved while result stalled");

endmodule

`default_nettype wire
